/* rtl/idle_connection_timing_wheel_top_macros.svh */
// Assertion macros used by the idle connection timing wheel top level.
`ifndef IDLE_CONNECTION_TIMING_WHEEL_TOP_MACROS_SVH
`define IDLE_CONNECTION_TIMING_WHEEL_TOP_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ICW_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ICW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/icw_pkg.sv */
// Types and constants of the idle connection timing wheel.
package icw_pkg;

  localparam int TimeW      = 32;
  localparam int IdW        = 6;
  localparam int IdleSecs   = 30;
  localparam int MaxResults = 64;
  localparam int CntW       = $clog2(MaxResults);
  localparam int StepBits   = 8;
  localparam int Steps      = TimeW / StepBits;
  localparam int StepCntW   = $clog2(Steps);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TOUCH  = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IdW-1:0]   conn_id;
    logic [TimeW-1:0] now;
  } in_t;

  typedef struct packed {
    logic [IdW-1:0] expired_id;
    logic           expired_valid;
    logic           last;
  } out_t;

  typedef struct packed {
    logic rd_en;
    logic vld_we;
    logic vld_wdata;
    logic dat_we;
  } tbl_ctl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_APPLY,
    ST_SCAN,
    ST_MARK
  } state_e;

endpackage

/* rtl/idle_connection_timing_wheel_top.sv */
// Top level of the idle connection timing wheel.
//
// Usage: present a transaction on in_i (op, conn_id, now) with start high;
// it is taken at the rising edge where start is high and busy is low.
// Insert and touch (the latter only on a valid entry) stamp the entry with
// now and slot now mod WHEEL_SLOTS, remove clears it; these give no result.
// A tick walks the whole table and expires every valid entry in slot now mod
// WHEEL_SLOTS that has been idle 30 s or more (at most 63 per tick, lowest
// ids first), then a marker. Results appear on res_o for one cycle each with
// res_strobe_o high; the receiver cannot stall, so every strobe is a
// delivered transaction.
// Timing: the slot is formed by a remainder unit working one byte of now
// per cycle; insert, remove and touch then update the table and return to
// idle. A tick adds a pipelined walk of the table memory, one entry per
// cycle, and the marker. Expiries stream out during the walk, at most one
// per cycle; the marker follows the last entry.
// Reset: the valid-bit memory is swept to zero, one entry per cycle, after
// reset; busy stays high throughout.
`include "idle_connection_timing_wheel_top_macros.svh"

module idle_connection_timing_wheel_top import icw_pkg::*; #(
  parameter int MAX_CONN    = 64,
  parameter int WHEEL_SLOTS = 30
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  in_i,
  output logic res_strobe_o,
  output out_t res_o
);

  localparam int AW   = $clog2(MAX_CONN);
  localparam int SW   = $clog2(WHEEL_SLOTS);
  localparam int IdxW = AW + 1;

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            eval_q, eval_d;
  logic [AW-1:0]   eval_idx_q, eval_idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  in_t             item_q, item_d;
  out_t            res_q, res_d;
  logic            strobe_q, strobe_d;

  tbl_ctl_t         tbl_ctl;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic             rd_valid;
  logic [SW-1:0]    rd_slot;
  logic [TimeW-1:0] rd_seen;

  logic             mod_start, mod_done;
  logic [SW-1:0]    mod_rem;

  logic             in_range;
  logic [AW-1:0]    id_addr;
  logic [TimeW-1:0] idle_time;
  logic             expire;

  icw_mod #(
    .Div  (WHEEL_SLOTS),
    .RemW (SW)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .value_i (in_i.now),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  icw_table #(
    .Depth (MAX_CONN),
    .AddrW (AW),
    .SlotW (SW)
  ) u_table (
    .clk_i      (clk_i),
    .ctl_i      (tbl_ctl),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .wr_slot_i  (mod_rem),
    .wr_seen_i  (item_q.now),
    .rd_valid_o (rd_valid),
    .rd_slot_o  (rd_slot),
    .rd_seen_o  (rd_seen)
  );

  // Ids at or above the table depth are dropped by insert, remove and touch.
  assign in_range  = 32'(item_q.conn_id) < 32'(MAX_CONN);
  assign id_addr   = AW'(item_q.conn_id);
  assign idle_time = item_q.now - rd_seen;

  // Expire only when the clock has not gone backwards and the cap allows.
  assign expire = eval_q && rd_valid && (rd_slot == mod_rem) &&
                  (item_q.now >= rd_seen) && (idle_time >= TimeW'(IdleSecs)) &&
                  (cnt_q < CntW'(MaxResults - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (idx_q == IdxW'(MAX_CONN - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_d = (item_q.op == OP_TICK) ? ST_SCAN : ST_APPLY;
        end
      end
      ST_APPLY: state_d = ST_IDLE;
      ST_SCAN: begin
        if ((idx_q == IdxW'(MAX_CONN)) && !eval_q) begin
          state_d = ST_MARK;
        end
      end
      ST_MARK:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    idx_d      = idx_q;
    eval_d     = 1'b0;
    eval_idx_d = eval_idx_q;
    cnt_d      = cnt_q;
    item_d     = item_q;
    res_d      = res_q;
    strobe_d   = 1'b0;
    mod_start  = 1'b0;
    tbl_ctl    = '0;
    rd_addr    = '0;
    wr_addr    = '0;
    case (state_q)
      ST_CLEAR: begin
        tbl_ctl.vld_we = 1'b1;
        wr_addr        = idx_q[AW-1:0];
        idx_d          = idx_q + 1'b1;
      end
      ST_IDLE: begin
        if (start) begin
          // Fetch the entry now so touch can test its valid bit later.
          item_d        = in_i;
          mod_start     = 1'b1;
          tbl_ctl.rd_en = 1'b1;
          rd_addr       = AW'(in_i.conn_id);
          idx_d         = '0;
          cnt_d         = '0;
        end
      end
      ST_MOD: begin
      end
      ST_APPLY: begin
        wr_addr = id_addr;
        if (in_range) begin
          case (item_q.op)
            OP_INSERT: begin
              tbl_ctl.vld_we    = 1'b1;
              tbl_ctl.vld_wdata = 1'b1;
              tbl_ctl.dat_we    = 1'b1;
            end
            OP_REMOVE: tbl_ctl.vld_we = 1'b1;
            OP_TOUCH:  tbl_ctl.dat_we = rd_valid;
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Issue the next read while the previous entry is judged.
        if (idx_q != IdxW'(MAX_CONN)) begin
          tbl_ctl.rd_en = 1'b1;
          rd_addr       = idx_q[AW-1:0];
          idx_d         = idx_q + 1'b1;
          eval_d        = 1'b1;
          eval_idx_d    = idx_q[AW-1:0];
        end
        wr_addr = eval_idx_q;
        if (expire) begin
          tbl_ctl.vld_we      = 1'b1;
          res_d.expired_id    = IdW'(eval_idx_q);
          res_d.expired_valid = 1'b1;
          res_d.last          = 1'b0;
          strobe_d            = 1'b1;
          cnt_d               = cnt_q + 1'b1;
        end
      end
      ST_MARK: begin
        res_d.expired_id    = '0;
        res_d.expired_valid = 1'b0;
        res_d.last          = 1'b1;
        strobe_d            = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      idx_q    <= '0;
      eval_q   <= 1'b0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      eval_q   <= eval_d;
      cnt_q    <= cnt_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eval_idx_q <= eval_idx_d;
    item_q     <= item_d;
    res_q      <= res_d;
  end

  assign busy         = (state_q != ST_IDLE);
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

  // An accepted transaction must leave idle straight away.
  `ICW_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy,
                   "accepted transaction did not raise busy")
  // The walk must never read and rewrite the same entry in one cycle.
  `ICW_ASSERT_SAME(a_no_rw_clash, clk_i, rst_ni, tbl_ctl.rd_en && tbl_ctl.vld_we,
                   rd_addr != wr_addr, "table read and write hit the same entry")
  // A tick delivers at most one fewer expiry than the result limit.
  `ICW_ASSERT_SAME(a_cap, clk_i, rst_ni, expire, cnt_q != CntW'(MaxResults - 1),
                   "expiry issued beyond the per-tick limit")
  // The closing marker only follows the marker state.
  `ICW_ASSERT_SAME(a_marker_src, clk_i, rst_ni, res_strobe_o && res_o.last,
                   $past(state_q) == ST_MARK, "closing marker outside a tick")

endmodule

/* rtl/icw_mod.sv */
// Multi-cycle remainder unit: time value modulo the number of wheel slots.
module icw_mod import icw_pkg::*; #(
  parameter int Div  = 30,
  parameter int RemW = $clog2(Div)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [TimeW-1:0] value_i,
  output logic             done_o,
  output logic [RemW-1:0]  rem_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic [TimeW-1:0]    val_q, val_d;
  logic [RemW-1:0]     r_q, r_d;

  // Restoring reduction, one byte of the dividend per cycle, MSB first.
  always_comb begin
    logic [RemW-1:0] r;
    logic [RemW:0]   t;
    r = r_q;
    t = '0;
    for (int k = 0; k < StepBits; k++) begin
      t = {r, val_q[TimeW-1-k]};
      if (t >= (RemW+1)'(Div)) begin
        t = t - (RemW+1)'(Div);
      end
      r = t[RemW-1:0];
    end
    r_d    = r_q;
    val_d  = val_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      r_d    = '0;
      val_d  = value_i;
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      r_d   = r;
      val_d = val_q << StepBits;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == StepCntW'(Steps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    val_q <= val_d;
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

/* rtl/icw_table.sv */
// Connection table: valid-bit memory and time/slot memory, registered reads.
module icw_table import icw_pkg::*; #(
  parameter int Depth = 64,
  parameter int AddrW = $clog2(Depth),
  parameter int SlotW = 5
) (
  input  logic             clk_i,
  input  tbl_ctl_t         ctl_i,
  input  logic [AddrW-1:0] rd_addr_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [SlotW-1:0] wr_slot_i,
  input  logic [TimeW-1:0] wr_seen_i,
  output logic             rd_valid_o,
  output logic [SlotW-1:0] rd_slot_o,
  output logic [TimeW-1:0] rd_seen_o
);

  logic                   vld_mem [Depth];
  logic [SlotW+TimeW-1:0] dat_mem [Depth];
  logic                   rd_valid_q;
  logic [SlotW+TimeW-1:0] rd_dat_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.vld_we) begin
      vld_mem[wr_addr_i] <= ctl_i.vld_wdata;
    end
    if (ctl_i.dat_we) begin
      dat_mem[wr_addr_i] <= {wr_slot_i, wr_seen_i};
    end
  end

  // Hold the read data until the next read.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_valid_q <= vld_mem[rd_addr_i];
      rd_dat_q   <= dat_mem[rd_addr_i];
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_slot_o  = rd_dat_q[SlotW+TimeW-1:TimeW];
  assign rd_seen_o  = rd_dat_q[TimeW-1:0];

endmodule
